/* src/sat_pkg.sv */
// package: word types, state codes and fixed widths for the summed-area table core
`timescale 1ns / 1ps

package sat_pkg;

	localparam int SUM_W     = 28;
	localparam int RUN_W     = 22;
	localparam int CNT_W     = 7;
	localparam int IN_CELL_W = 16;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

	typedef struct packed {
		logic                        func;
		logic signed [IN_CELL_W-1:0] cell_value;
		logic        [CNT_W-1:0]     row_top;
		logic        [CNT_W-1:0]     row_bottom;
		logic        [CNT_W-1:0]     col_left;
		logic        [CNT_W-1:0]     col_right;
	} in_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] rect_sum;
		logic                    query_error;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_RUN,
		ST_LD_WR,
		ST_Q_CHK,
		ST_Q_RD,
		ST_Q_END
	} state_t;

endpackage

/* src/sat_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sat_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/summed_area_table_rect_sum_core.sv */
// top level: summed-area table build and rectangle-sum query core
// A load word (func 0) keeps busy high through ST_LD_RUN, which adds the cell into the row
// running sum while the entry above is read, and ST_LD_WR, which adds and writes the table
// entry. A query word (func 1) is checked in the first busy cycle; a bad rectangle or an
// incomplete grid ends it there, otherwise the four corner entries are read one per
// cycle through the single table read port and folded in by the one shared adder, so a
// good query keeps busy high through ST_Q_CHK, ST_Q_RD and ST_Q_END. The result appears
// on result for exactly one cycle with result_valid, in the first cycle with busy low,
// and cannot be held off; a new word may be started in that same cycle. The table needs
// no clearing pass after reset. Configuration writes restart loading at the first cell.
`timescale 1ns / 1ps

module summed_area_table_rect_sum_core #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 64,
	parameter int CELL_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  sat_pkg::in_word_t           in_word,
	output logic                        result_valid,
	output sat_pkg::out_word_t          result,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [sat_pkg::CNT_W-1:0]   cfg_data
);

	localparam int RCW    = $clog2(MAX_ROWS + 1);
	localparam int CCW    = $clog2(MAX_COLS + 1);
	localparam int CMPW_A = (RCW > CCW) ? RCW : CCW;
	localparam int CMPW   = (CMPW_A > sat_pkg::CNT_W) ? CMPW_A : sat_pkg::CNT_W;
	localparam int ROW_AW = $clog2(MAX_ROWS);
	localparam int COL_AW = $clog2(MAX_COLS);
	localparam int AW     = ROW_AW + COL_AW;
	localparam int DEPTH  = 2 ** AW;
	localparam bit SIGN_EXT = (CELL_BITS <= sat_pkg::IN_CELL_W);
	localparam int SIGN_IDX = SIGN_EXT ? CELL_BITS - 1 : sat_pkg::IN_CELL_W - 1;
	localparam int SW = sat_pkg::SUM_W;
	localparam int RW = sat_pkg::RUN_W;

	sat_pkg::state_t state_q, state_d;

	logic [sat_pkg::CNT_W-1:0] row_count_q, col_count_q;
	logic [RCW-1:0]            load_row_q;
	logic [CCW-1:0]            load_col_q;
	logic [RW-1:0]             run_q;
	logic                      grid_q;
	logic [RW-1:0]             cell_q;
	logic [CMPW-1:0]           qt_q, qb_q, ql_q, qr_q;
	logic [1:0]                k_q;
	logic [SW-1:0]             acc_q;
	logic                      zero_s1;
	logic                      result_valid_q;
	sat_pkg::out_word_t        result_q;

	logic [CMPW-1:0] rows_used, cols_used, cnt_r, cnt_c;
	logic [CMPW-1:0] cur_r, cur_c, rd_row, rd_col;
	logic            pos_bad, q_bad, rd_zero;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic [SW-1:0]   rd_data, data_eff, add_a, add_b, add_y;
	logic            add_sub, ram_we;
	logic [RW-1:0]   cell_ext, cv_w;
	logic [1:0]      term;

	// saturate counts to 1..max
	always_comb begin
		cnt_r = CMPW'(row_count_q);
		cnt_c = CMPW'(col_count_q);
		if (cnt_r == '0) begin
			rows_used = CMPW'(1);
		end else if (cnt_r > CMPW'(MAX_ROWS)) begin
			rows_used = CMPW'(MAX_ROWS);
		end else begin
			rows_used = cnt_r;
		end
		if (cnt_c == '0) begin
			cols_used = CMPW'(1);
		end else if (cnt_c > CMPW'(MAX_COLS)) begin
			cols_used = CMPW'(MAX_COLS);
		end else begin
			cols_used = cnt_c;
		end
	end

	// low cell bits, sign-extended when CELL_BITS fits the input field, else zero-extended
	always_comb begin
		cv_w = {{(RW - sat_pkg::IN_CELL_W){1'b0}}, in_word.cell_value};
		for (int i = 0; i < RW; i++) begin
			if (i < CELL_BITS && i < sat_pkg::IN_CELL_W) begin
				cell_ext[i] = cv_w[i];
			end else if (SIGN_EXT) begin
				cell_ext[i] = cv_w[SIGN_IDX];
			end else begin
				cell_ext[i] = 1'b0;
			end
		end
	end

	assign cur_r   = CMPW'(load_row_q);
	assign cur_c   = CMPW'(load_col_q);
	assign pos_bad = (cur_r == '0) || (cur_r > rows_used) || (cur_c == '0) ||
	                 (cur_c > cols_used);
	assign q_bad   = !grid_q || (qt_q == '0) || (ql_q == '0) || (qt_q > qb_q) ||
	                 (ql_q > qr_q) || (qb_q > rows_used) || (qr_q > cols_used);

	assign busy = (state_q != sat_pkg::ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sat_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (in_word.func == sat_pkg::FUNC_QUERY) ? sat_pkg::ST_Q_CHK :
					          sat_pkg::ST_LD_RUN;
				end
			end
			sat_pkg::ST_LD_RUN: state_d = sat_pkg::ST_LD_WR;
			sat_pkg::ST_LD_WR:  state_d = sat_pkg::ST_IDLE;
			sat_pkg::ST_Q_CHK:  state_d = q_bad ? sat_pkg::ST_IDLE : sat_pkg::ST_Q_RD;
			sat_pkg::ST_Q_RD:   state_d = (k_q == 2'd3) ? sat_pkg::ST_Q_END : sat_pkg::ST_Q_RD;
			sat_pkg::ST_Q_END:  state_d = sat_pkg::ST_IDLE;
			default:            state_d = sat_pkg::ST_IDLE;
		endcase
	end

	// datapath control and shared adder operands
	assign term     = k_q - 2'd1;
	assign data_eff = zero_s1 ? '0 : rd_data;

	always_comb begin
		rd_row  = cur_r - CMPW'(1);
		rd_col  = cur_c;
		add_a   = {{(SW - RW){run_q[RW-1]}}, run_q};
		add_b   = data_eff;
		add_sub = 1'b0;
		ram_we  = 1'b0;
		case (state_q)
			sat_pkg::ST_LD_RUN: begin
				add_b = {{(SW - RW){cell_q[RW-1]}}, cell_q};
			end
			sat_pkg::ST_LD_WR: begin
				ram_we = 1'b1;
			end
			sat_pkg::ST_Q_RD, sat_pkg::ST_Q_END: begin
				rd_row  = k_q[0] ? qt_q - CMPW'(1) : qb_q;
				rd_col  = k_q[1] ? ql_q - CMPW'(1) : qr_q;
				add_a   = acc_q;
				add_sub = term[0] ^ term[1];
			end
			default: begin
			end
		endcase
	end

	assign rd_zero = (rd_row == '0) || (rd_col == '0);
	assign rd_addr = {ROW_AW'(rd_row - CMPW'(1)), COL_AW'(rd_col - CMPW'(1))};
	assign wr_addr = {ROW_AW'(cur_r - CMPW'(1)), COL_AW'(cur_c - CMPW'(1))};
	assign add_y   = add_sub ? add_a - add_b : add_a + add_b;

	sat_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(add_y),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sat_pkg::ST_IDLE;
			row_count_q    <= sat_pkg::COUNT_RESET;
			col_count_q    <= sat_pkg::COUNT_RESET;
			load_row_q     <= RCW'(1);
			load_col_q     <= CCW'(1);
			run_q          <= '0;
			grid_q         <= 1'b0;
			k_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= 1'b0;
			case (state_q)
				sat_pkg::ST_IDLE: begin
					k_q <= '0;
					if (start && in_word.func == sat_pkg::FUNC_LOAD && pos_bad) begin
						load_row_q <= RCW'(1);
						load_col_q <= CCW'(1);
						run_q      <= '0;
						grid_q     <= 1'b0;
					end
				end
				sat_pkg::ST_LD_RUN: begin
					run_q <= add_y[RW-1:0];
					if (cur_r == CMPW'(1) && cur_c == CMPW'(1)) begin
						grid_q <= 1'b0;
					end
				end
				sat_pkg::ST_LD_WR: begin
					if (cur_c >= cols_used) begin
						load_col_q <= CCW'(1);
						run_q      <= '0;
						if (cur_r >= rows_used) begin
							load_row_q <= RCW'(1);
							grid_q     <= 1'b1;
						end else begin
							load_row_q <= load_row_q + RCW'(1);
						end
					end else begin
						load_col_q <= load_col_q + CCW'(1);
					end
				end
				sat_pkg::ST_Q_CHK: begin
					if (q_bad) begin
						result_valid_q <= 1'b1;
					end
				end
				sat_pkg::ST_Q_RD: begin
					k_q <= k_q + 2'd1;
				end
				sat_pkg::ST_Q_END: begin
					result_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
			// register write restarts loading
			if (cfg_we) begin
				if (cfg_index == sat_pkg::REG_ROW_COUNT) begin
					row_count_q <= cfg_data;
				end else begin
					col_count_q <= cfg_data;
				end
				load_row_q <= RCW'(1);
				load_col_q <= CCW'(1);
				run_q      <= '0;
				grid_q     <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		zero_s1 <= rd_zero;
		if (state_q == sat_pkg::ST_IDLE && start) begin
			cell_q <= cell_ext;
			qt_q   <= CMPW'(in_word.row_top);
			qb_q   <= CMPW'(in_word.row_bottom);
			ql_q   <= CMPW'(in_word.col_left);
			qr_q   <= CMPW'(in_word.col_right);
		end
		case (state_q)
			sat_pkg::ST_Q_CHK: begin
				acc_q                <= '0;
				result_q.rect_sum    <= '0;
				result_q.query_error <= 1'b1;
			end
			sat_pkg::ST_Q_RD: begin
				if (k_q != 2'd0) begin
					acc_q <= add_y;
				end
			end
			sat_pkg::ST_Q_END: begin
				result_q.rect_sum    <= add_y;
				result_q.query_error <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == sat_pkg::ST_Q_CHK || state_q == sat_pkg::ST_Q_END))
		else $error("result word without a finished query");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.query_error |-> result.rect_sum == '0)
		else $error("error word carries a non-zero sum");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !cfg_we |=> busy)
		else $error("accepted word did not raise busy");

	a_grid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(grid_q) |-> $past(state_q == sat_pkg::ST_LD_WR))
		else $error("grid marked complete outside a table write");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		load_row_q != '0 && load_col_q != '0)
		else $error("load position left its range");

endmodule
